@@ src/dpe_pkg.sv @@
// shared types and constants for the distinct permutation enumerator
`default_nettype none

package dpe_pkg;

    // payload field widths
    localparam int CHAR_W     = 8;
    localparam int LEN_W      = 4;
    localparam int WORD_W     = 64;
    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 72;
    localparam int OUT_USER_W = 3;

    // default string capacity
    localparam int MAX_LEN_DEF = 8;

    typedef logic [CHAR_W-1:0] char_t;

    // command codes carried on the input tuser
    typedef enum logic [IN_USER_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_NEXT   = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BACK,
        ST_SCAN,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

@@ src/dpe_cand_chk.sv @@
// candidate check unit: tests one position against taken mask and earlier duplicates
`default_nettype none

module dpe_cand_chk
    import dpe_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF,
    parameter int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
)
(
    input  char_t              chars [MAX_LEN],
    input  logic [MAX_LEN-1:0] taken,
    input  logic [IDX_W-1:0]   cand,
    output logic               ok,
    output char_t              cand_char
);

    // character at the probed position
    assign cand_char = chars[cand];

    // an earlier free position with the same character blocks the candidate
    always_comb
    begin
        logic dup;
        dup = 1'b0;
        for (int q = 0; q < MAX_LEN; q++)
        begin
            if ((IDX_W'(q) < cand) && !taken[q] && (chars[q] == cand_char))
            begin
                dup = 1'b1;
            end
        end
        ok = !taken[cand] && !dup;
    end

endmodule

`default_nettype wire

@@ src/distinct_permutation_enumerator_core.sv @@
// distinct permutation enumerator: command decode, backtracking sequencer, output register
//
// usage
//   input channel s_axis: tuser carries the command (clear, append, next, nop),
//   tdata carries the character for an append. one request is taken only when
//   the sequencer is idle; the block is busy while it searches.
//   output channel m_axis: exactly one result per request. tdata holds the
//   permutation word and the string length, tuser the flags perm_valid,
//   all_done and append_overflow.
// sequencing
//   clear, append, nop and a next request on an empty or finished string go
//   from idle straight to the emit state, which loads the result into the
//   output register; the block then returns to idle for the next request.
//   a next request: a scan step per probed candidate position or level found
//   exhausted, a back step per backtracked level, then the emit state. the
//   single candidate check unit probes one position per cycle. a new request
//   is taken only after the result is in the output register.
// reset
//   empties the string and the enumeration state; no result is pending.
// stalls
//   a finished result waits in the output register while m_axis_tready is low;
//   the block still takes the next request and holds its own result until the
//   output register frees up.
`default_nettype none

module distinct_permutation_enumerator_core
    import dpe_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] char_in
    input  wire logic [IN_USER_W-1:0]  s_axis_tuser,   // [1:0] command
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // [63:0] perm_word, [67:64] perm_length
    output logic [OUT_USER_W-1:0]      m_axis_tuser    // [0] perm_valid, [1] all_done,
                                                       // [2] append_overflow
);

    localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    // control state
    state_t             state_reg, state_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [MAX_LEN-1:0] taken_reg, taken_next;
    logic               started_reg, started_next;
    logic               finished_reg, finished_next;
    logic [IDX_W-1:0]   depth_reg, depth_next;
    logic [LEN_W-1:0]   cand_reg, cand_next;
    logic               emit_perm_reg, emit_perm_next;
    logic               emit_ovf_reg, emit_ovf_next;

    // payload storage
    char_t              chars_reg [MAX_LEN];
    logic [IDX_W-1:0]   lvl_reg   [MAX_LEN];
    char_t              perm_reg  [MAX_LEN];

    logic               chars_we;
    logic               lvl_we;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_USER_W-1:0] out_user_reg;
    logic                  out_load;

    cmd_t               cmd;
    logic [IDX_W-1:0]   cand_idx;
    logic [IDX_W-1:0]   cur_idx;
    logic [MAX_LEN-1:0] cand_bit;
    logic [MAX_LEN-1:0] cur_bit;
    logic               cand_ok;
    char_t              cand_char;
    logic [LEN_W-1:0]   last_level;
    logic [WORD_W-1:0]  word;

    assign cmd        = cmd_t'(s_axis_tuser);
    assign cand_idx   = cand_reg[IDX_W-1:0];
    assign cur_idx    = lvl_reg[depth_reg];
    assign cand_bit   = MAX_LEN'(1) << cand_idx;
    assign cur_bit    = MAX_LEN'(1) << cur_idx;
    assign last_level = len_reg - LEN_W'(1);

    // shared candidate check unit
    dpe_cand_chk #(
        .MAX_LEN (MAX_LEN),
        .IDX_W   (IDX_W)
    ) u_cand_chk (
        .chars     (chars_reg),
        .taken     (taken_reg),
        .cand      (cand_idx),
        .ok        (cand_ok),
        .cand_char (cand_char)
    );

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if ((cmd == CMD_NEXT) && !finished_reg && (len_reg != '0))
                    begin
                        state_next = started_reg ? ST_BACK : ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_BACK:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (cand_reg >= len_reg)
                begin
                    state_next = (depth_reg == '0) ? ST_EMIT : ST_BACK;
                end
                else if (cand_ok && (LEN_W'(depth_reg) == last_level))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs and datapath next values
    always_comb
    begin
        len_next       = len_reg;
        taken_next     = taken_reg;
        started_next   = started_reg;
        finished_next  = finished_reg;
        depth_next     = depth_reg;
        cand_next      = cand_reg;
        emit_perm_next = emit_perm_reg;
        emit_ovf_next  = emit_ovf_reg;
        chars_we       = 1'b0;
        lvl_we         = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    emit_perm_next = 1'b0;
                    emit_ovf_next  = 1'b0;
                    unique case (cmd)
                        CMD_CLEAR:
                        begin
                            len_next      = '0;
                            taken_next    = '0;
                            started_next  = 1'b0;
                            finished_next = 1'b0;
                        end
                        CMD_APPEND:
                        begin
                            if (len_reg < LEN_W'(MAX_LEN))
                            begin
                                chars_we      = 1'b1;
                                len_next      = len_reg + LEN_W'(1);
                                taken_next    = '0;
                                started_next  = 1'b0;
                                finished_next = 1'b0;
                            end
                            else
                            begin
                                emit_ovf_next = 1'b1;
                            end
                        end
                        CMD_NEXT:
                        begin
                            if (!finished_reg)
                            begin
                                if (len_reg == '0)
                                begin
                                    finished_next = 1'b1;
                                    started_next  = 1'b1;
                                    taken_next    = '0;
                                end
                                else if (!started_reg)
                                begin
                                    taken_next = '0;
                                    depth_next = '0;
                                    cand_next  = '0;
                                end
                                else
                                begin
                                    depth_next = last_level[IDX_W-1:0];
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_BACK:
            begin
                // release the current choice and resume just past it
                taken_next = taken_reg & ~cur_bit;
                cand_next  = LEN_W'(cur_idx) + LEN_W'(1);
            end
            ST_SCAN:
            begin
                if (cand_reg >= len_reg)
                begin
                    if (depth_reg == '0)
                    begin
                        finished_next = 1'b1;
                        started_next  = 1'b1;
                        taken_next    = '0;
                    end
                    else
                    begin
                        depth_next = depth_reg - IDX_W'(1);
                    end
                end
                else if (cand_ok)
                begin
                    lvl_we     = 1'b1;
                    taken_next = taken_reg | cand_bit;
                    if (LEN_W'(depth_reg) == last_level)
                    begin
                        started_next   = 1'b1;
                        emit_perm_next = 1'b1;
                    end
                    else
                    begin
                        depth_next = depth_reg + IDX_W'(1);
                        cand_next  = '0;
                    end
                end
                else
                begin
                    cand_next = cand_reg + LEN_W'(1);
                end
            end
            ST_EMIT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            taken_reg     <= '0;
            started_reg   <= 1'b0;
            finished_reg  <= 1'b0;
            depth_reg     <= '0;
            cand_reg      <= '0;
            emit_perm_reg <= 1'b0;
            emit_ovf_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            taken_reg     <= taken_next;
            started_reg   <= started_next;
            finished_reg  <= finished_next;
            depth_reg     <= depth_next;
            cand_reg      <= cand_next;
            emit_perm_reg <= emit_perm_next;
            emit_ovf_reg  <= emit_ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // string and level stack storage
    always_ff @(posedge clk)
    begin
        if (chars_we)
        begin
            chars_reg[len_reg[IDX_W-1:0]] <= char_t'(s_axis_tdata);
        end
        if (lvl_we)
        begin
            lvl_reg[depth_reg]  <= cand_idx;
            perm_reg[depth_reg] <= cand_char;
        end
    end

    // permutation word from the chosen characters
    always_comb
    begin
        word = '0;
        if (emit_perm_reg)
        begin
            for (int k = 0; k < MAX_LEN; k++)
            begin
                if (LEN_W'(k) < len_reg)
                begin
                    word[k*CHAR_W +: CHAR_W] = perm_reg[k];
                end
            end
        end
    end

    // output register handshake
    assign out_load = (state_reg == ST_EMIT) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= {(OUT_DATA_W - WORD_W - LEN_W)'(0), len_reg, word};
            out_user_reg <= {emit_ovf_reg, finished_reg, emit_perm_reg};
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // a result never carries a permutation and the exhausted flag together
    a_perm_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("permutation and exhausted flag both set");

    // a permutation result always has a non-empty string
    a_perm_len: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[67:64] != 4'd0))
        else $error("permutation with zero length");

    // never more positions taken than characters loaded
    a_taken_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(taken_reg) <= int'(len_reg))
        else $error("taken mask exceeds string length");

    // search depth stays inside the string
    a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) || (state_reg == ST_BACK)) |-> (LEN_W'(depth_reg) < len_reg))
        else $error("search depth out of range");

endmodule

`default_nettype wire
